[rtl/text_console_writer_assert.svh]
// Assertion macros used by the console back end.
// Each macro expands to one labeled concurrent assertion that is off during reset.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCW_ASSERT_IMPLY(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

[rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
// No dependencies; the top level, front end, queue and back end use it by scoped names.
package tcw_pkg;

    // Command codes
    localparam logic [1:0] CMD_PRINT = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Value of a blanked character or attribute byte
    localparam logic [7:0] BLANK_BYTE = 8'h00;

    // Row field of a queued operation: covers the largest supported row count
    localparam int OP_ROW_W = 6;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic       first;
        logic [6:0] start_col;
        logic [4:0] start_row;
        logic [3:0] fg_color;
        logic [3:0] bg_color;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_PRINT_COPY,
        OP_PRINT_BLANK,
        OP_CLEAR,
        OP_READ
    } op_kind_t;

    // One classified command, as passed from the front end to the back end
    typedef struct packed {
        op_kind_t              kind;
        logic [4:0]            lines;
        logic [OP_ROW_W-1:0]   row;
        logic [6:0]            col;
        logic [7:0]            ch;
        logic [7:0]            attr;
        logic [6:0]            cursor_col;
        logic [4:0]            cursor_row;
    } op_t;

endpackage

[rtl/text_console_writer.sv]
// Top level of the text console writer: front end, operation queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_fifo, tcw_back (and through it tcw_ram).
//
//  channel | handshake           | payload            | direction
//  --------+---------------------+--------------------+----------
//  cmd     | cmd_valid/cmd_stall | tcw_pkg::cmd_t     | into block
//  rsp     | rsp_valid/rsp_stall | tcw_pkg::rsp_t     | out of block
//
// Print and read pop the queue (and issue the read), then write the cell or capture
// the read data into the result register. Clear blanks every cell; a one-row scroll
// copies rows up and blanks the bottom; a scroll that blanks the whole screen blanks
// every cell. After reset a clearing pass over every cell holds cmd_stall high;
// cmd_stall is also high while the two-entry queue is full, and a stalled result
// holds the back end.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  tcw_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tcw_pkg::rsp_t rsp
);

    // front end -> queue
    logic         push;
    tcw_pkg::op_t push_op;
    logic         queue_full;

    // queue -> back end
    logic         pop;
    logic         queue_empty;
    tcw_pkg::op_t head;

    // back end status: store still being cleared after reset
    logic         init_busy;

    // Front end: owns the cursor, so a command is classified and its
    // reported cursor fixed the cycle it is transferred.
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_stall  (cmd_stall),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .push       (push),
        .push_op    (push_op)
    );

    tcw_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .pop     (pop),
        .head    (head),
        .empty   (queue_empty)
    );

    // Back end: applies operations to the cell RAM in order and
    // produces one result per operation.
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_avail  (!queue_empty),
        .head      (head),
        .pop       (pop),
        .init_busy (init_busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tcw_front.sv]
// Front end: accepts commands, tracks the cursor, classifies each command.
// Depends on tcw_pkg.
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  tcw_pkg::cmd_t cmd,
    output logic          cmd_stall,
    input  logic          queue_full,
    input  logic          init_busy,
    output logic          push,
    output tcw_pkg::op_t  push_op
);

    localparam int CUR_CW = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CXW    = (CUR_CW > 7) ? CUR_CW : 7;
    localparam int RXW    = ((ROW_W > 5) ? ROW_W : 5) + 1;
    localparam int OPRW   = tcw_pkg::OP_ROW_W;

    logic [CUR_CW-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic [CXW-1:0] c0, c1, c2, cur_c;
    logic [RXW-1:0] r0, r1, r2, lines, cur_r;
    logic           wrap, scroll, rd_ok;

    assign cmd_stall = init_busy || queue_full;
    assign push      = cmd_valid && !cmd_stall;

    always_comb
    begin
        // wrap, then scroll, then place the character
        c0     = cmd.first ? CXW'(cmd.start_col) : CXW'(col_reg);
        wrap   = c0 >= CXW'(COLUMNS);
        c1     = wrap ? '0 : c0;
        c2     = c1 + CXW'(1);
        r0     = cmd.first ? RXW'(cmd.start_row) : RXW'(row_reg);
        r1     = r0 + RXW'(wrap);
        scroll = r1 >= RXW'(ROWS);
        lines  = r1 - RXW'(ROWS - 1);
        r2     = scroll ? RXW'(ROWS - 1) : r1;
        cur_c  = CXW'(col_reg);
        cur_r  = RXW'(row_reg);
        rd_ok  = (CXW'(cmd.start_col) < CXW'(COLUMNS)) &&
                 (RXW'(cmd.start_row) < RXW'(ROWS));

        push_op.kind       = tcw_pkg::OP_NOP;
        push_op.lines      = '0;
        push_op.row        = OPRW'(cmd.start_row);
        push_op.col        = cmd.start_col;
        push_op.ch         = cmd.char_code;
        push_op.attr       = {cmd.bg_color, cmd.fg_color};
        push_op.cursor_col = cur_c[6:0];
        push_op.cursor_row = cur_r[4:0];
        col_next           = col_reg;
        row_next           = row_reg;

        case (cmd.command)
            tcw_pkg::CMD_PRINT:
            begin
                if (!scroll)
                begin
                    push_op.kind = tcw_pkg::OP_PRINT;
                end
                else if (lines >= RXW'(ROWS))
                begin
                    push_op.kind = tcw_pkg::OP_PRINT_BLANK;
                end
                else
                begin
                    push_op.kind = tcw_pkg::OP_PRINT_COPY;
                end
                push_op.lines      = lines[4:0];
                push_op.row        = OPRW'(r2);
                push_op.col        = c1[6:0];
                push_op.cursor_col = c2[6:0];
                push_op.cursor_row = r2[4:0];
                if (push)
                begin
                    col_next = CUR_CW'(c2);
                    row_next = ROW_W'(r2);
                end
            end
            tcw_pkg::CMD_CLEAR:
            begin
                push_op.kind = tcw_pkg::OP_CLEAR;
            end
            tcw_pkg::CMD_READ:
            begin
                push_op.kind = rd_ok ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
            end
            default:
            begin
                push_op.kind = tcw_pkg::OP_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/tcw_fifo.sv]
// Two-entry operation queue between front end and back end.
// Depends on tcw_pkg.
module tcw_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  tcw_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output tcw_pkg::op_t head,
    output logic         empty
);

    localparam int QD  = 2;
    localparam int QPW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    tcw_pkg::op_t   slot_reg [QD];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign full  = count_reg == QCW'(QD);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QD - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QD - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tcw_back.sv]
// Back end: runs queued operations against the cell store, owns the result register.
// Depends on tcw_pkg, tcw_ram and text_console_writer_assert.svh.
`include "text_console_writer_assert.svh"

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_avail,
    input  tcw_pkg::op_t  head,
    output logic          pop,
    output logic          init_busy,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tcw_pkg::rsp_t rsp
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_COPY   = 5'b00100,
        ST_BLANK  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    tcw_pkg::op_t  op_reg, op_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    tcw_pkg::rsp_t out_data_reg, out_data_next;

    logic [AW+7:0] head_idx;
    logic [AW-1:0] head_addr;
    logic [CW+4:0] head_off_full;
    logic [CW-1:0] head_off;
    logic          out_free;
    logic          is_print;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign head_idx      = (AW+8)'(head.row) * (AW+8)'(COLUMNS) + (AW+8)'(head.col);
    assign head_addr     = head_idx[AW-1:0];
    assign head_off_full = (CW+5)'(head.lines) * (CW+5)'(COLUMNS);
    assign head_off      = head_off_full[CW-1:0];
    assign out_free      = !out_valid_reg || !rsp_stall;
    assign is_print      = op_reg.kind inside {tcw_pkg::OP_PRINT, tcw_pkg::OP_PRINT_COPY,
                                               tcw_pkg::OP_PRINT_BLANK};
    assign init_busy     = state_reg == ST_INIT;
    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && rsp_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = dst_reg;
        ram_wdata      = {tcw_pkg::BLANK_BYTE, tcw_pkg::BLANK_BYTE};
        ram_re         = 1'b0;
        ram_raddr      = head_addr;

        case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
                if (dst_reg == AW'(CELLS - 1))
                begin
                    dst_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dst_next = dst_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (op_avail)
                begin
                    pop       = 1'b1;
                    op_next   = head;
                    addr_next = head_addr;
                    case (head.kind)
                        tcw_pkg::OP_READ:
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_FINISH;
                        end
                        tcw_pkg::OP_CLEAR, tcw_pkg::OP_PRINT_BLANK:
                        begin
                            dst_next   = '0;
                            state_next = ST_BLANK;
                        end
                        tcw_pkg::OP_PRINT_COPY:
                        begin
                            src_next   = head_off;
                            dst_next   = '0;
                            state_next = ST_COPY;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                // read source ahead, write the word read last cycle
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    dst_next  = dst_reg + AW'(1);
                end
                if (src_reg != CW'(CELLS))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = src_reg[AW-1:0];
                    src_next  = src_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                ram_we = 1'b1;
                if (dst_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    dst_next = dst_reg + AW'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (is_print)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = addr_reg;
                        ram_wdata = {op_reg.attr, op_reg.ch};
                    end
                    out_valid_next = 1'b1;
                    out_data_next.cell_char  = (op_reg.kind == tcw_pkg::OP_READ) ?
                                               ram_rdata[7:0] : tcw_pkg::BLANK_BYTE;
                    out_data_next.cell_attr  = (op_reg.kind == tcw_pkg::OP_READ) ?
                                               ram_rdata[15:8] : tcw_pkg::BLANK_BYTE;
                    out_data_next.cursor_col = op_reg.cursor_col;
                    out_data_next.cursor_row = op_reg.cursor_row;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            src_reg       <= '0;
            dst_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
    end

    `TCW_ASSERT_IMPLY(a_wr_in_range, clk, rst_n, ram_we, ram_waddr <= AW'(CELLS - 1), "cell write beyond store")
    `TCW_ASSERT_IMPLY(a_copy_ahead, clk, rst_n, (state_reg == ST_COPY) && pend_reg && ram_re, CW'(dst_reg) < src_reg, "scroll copy overtook its source")
    `TCW_ASSERT_IMPLY(a_init_quiet, clk, rst_n, state_reg == ST_INIT, !out_valid_reg && !pop, "activity during clearing pass")
    `TCW_ASSERT_NEXT(a_finish_loads, clk, rst_n, (state_reg == ST_FINISH) && out_free, out_valid_reg && (state_reg == ST_IDLE), "finished operation gave no result")
    `TCW_ASSERT_IMPLY(a_pend_copy, clk, rst_n, pend_reg, state_reg == ST_COPY, "pending copy write outside scroll")

endmodule
